// ----- rtl/core/lif_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, constants and register codes of the neuron array.
// ----------------------------------------------------------------------------
package lif_pkg;

  localparam int CHANNELS   = 32;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SPIKE_CAP  = 32;
  localparam int SPK_CNT_W  = $clog2(SPIKE_CAP + 1);
  localparam int CHAN_W     = 5;
  localparam int AMP_W      = 21;
  localparam int TIME_W     = 32;
  localparam int NOISE_W    = 11;

  typedef logic signed [19:0] pot_t;
  typedef logic signed [16:0] stim_t;

  localparam pot_t  REST_Q8    = -20'sd17920;
  localparam pot_t  THRESH_Q8  = -20'sd14080;
  localparam pot_t  RESET_Q8   = -20'sd23040;
  localparam pot_t  POT_MAX    = 20'sd524287;
  localparam pot_t  POT_MIN    = -20'sd524288;
  localparam stim_t STIM_POS   = 17'sd38400;
  localparam stim_t STIM_NEG   = -17'sd38400;
  localparam logic [AMP_W-1:0] AMP_BASE = 21'd25600;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [7:0] LEAK_RST  = 8'd26;
  localparam logic [7:0] DECAY_RST = 8'd205;

  // register indexes
  localparam logic [1:0] REG_LEAK  = 2'd0;
  localparam logic [1:0] REG_DECAY = 2'd1;
  localparam logic [1:0] REG_NOISE = 2'd2;

  // result of one channel update
  typedef struct packed {
    logic             fire;
    logic [AMP_W-1:0] amp;
    pot_t             pot;
    stim_t            stim;
  } upd_t;

endpackage

// ----- rtl/core/lif_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_cell
// One ring cell: holds potential and stimulus of one channel slot.
// ----------------------------------------------------------------------------
module lif_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  lif_pkg::pot_t  pot_in,
  input  lif_pkg::stim_t stim_in,
  input  logic          wr_en,
  input  lif_pkg::stim_t wr_stim,
  output lif_pkg::pot_t  pot_out,
  output lif_pkg::stim_t stim_out
);
  import lif_pkg::*;

  pot_t  pot_r;
  stim_t stim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pot_r  <= REST_Q8;
      stim_r <= '0;
    end else if (shift_en) begin
      pot_r  <= pot_in;
      stim_r <= stim_in;
    end else if (wr_en) begin
      stim_r <= wr_stim;
    end
  end

  assign pot_out  = pot_r;
  assign stim_out = stim_r;

endmodule

// ----- rtl/core/lif_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_update
// Channel update: leak, integrate, noise, saturate, fire, stimulus decay.
// ----------------------------------------------------------------------------
module lif_update (
  input  lif_pkg::pot_t                      pot_i,
  input  lif_pkg::stim_t                     stim_i,
  input  logic [7:0]                         leak_i,
  input  logic [7:0]                         decay_i,
  input  logic signed [lif_pkg::NOISE_W-1:0] noise_i,
  output lif_pkg::upd_t                      upd_o
);
  import lif_pkg::*;

  logic signed [20:0] diff;
  logic signed [29:0] leak_prod;
  logic signed [21:0] leak_term;
  logic signed [23:0] sum;
  pot_t               v;
  logic [20:0]        over;
  logic [16:0]        mag;
  logic [24:0]        mag_prod;
  logic [16:0]        mag_q;

  always_comb begin
    diff      = 21'(REST_Q8) - 21'(pot_i);
    leak_prod = 30'(diff) * $signed({22'b0, leak_i});
    // floor division by 256
    leak_term = leak_prod[29:8];
    sum       = 24'(pot_i) + 24'(leak_term) + (24'(stim_i) <<< 2) + 24'(stim_i)
              + 24'(noise_i);
    if (sum > 24'(POT_MAX)) begin
      v = POT_MAX;
    end else if (sum < 24'(POT_MIN)) begin
      v = POT_MIN;
    end else begin
      v = sum[19:0];
    end
    over           = 21'(v) - 21'(THRESH_Q8);
    upd_o.fire     = (v > THRESH_Q8);
    upd_o.amp      = AMP_BASE + {over[19:0], 1'b0};
    upd_o.pot      = upd_o.fire ? RESET_Q8 : v;
    // decay the magnitude, truncating toward zero
    mag            = stim_i[16] ? 17'(-stim_i) : 17'(stim_i);
    mag_prod       = 25'(mag) * 25'(decay_i);
    mag_q          = mag_prod[24:8];
    upd_o.stim     = stim_i[16] ? stim_t'(-mag_q) : stim_t'(mag_q);
  end

endmodule

// ----- rtl/core/leaky_integrate_fire_array.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leaky_integrate_fire_array
// Array of leaky integrate-and-fire neurons kept in a rotating ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions are taken on a rising edge with start high and busy
//   low. in_kind = 1 writes the clamped stimulus of in_channel in that same
//   edge; busy stays low, so a set-stimulus transaction can follow each cycle.
//   in_kind = 0 is a tick: the tick counter advances and busy stays high
//   through the tick.  During the tick the cell ring rotates one slot per
//   cycle, and the single update unit at its head processes one channel per
//   cycle in ascending order; a final flush state then releases the last
//   spike.
//   Each spike is one transaction on the out_ ports, shown for exactly one
//   cycle with out_valid high.  A spike is held back until the next spike of
//   the tick (or the end of the tick) so that out_last can mark the final one.
//   At most SPIKE_CAP (32) spikes are reported per tick; later channels still
//   fire and reset.  The receiver cannot stall; results are never held.
//   The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//   leak_factor at 0x0, stim_decay at 0x4 and noise_enable at 0x8; pready
//   is tied high.  Synchronous reset restores all potentials to -70 mV,
//   stimuli to zero, the tick counter to zero and the noise LFSR to its seed.
// ----------------------------------------------------------------------------
module leaky_integrate_fire_array (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_kind,
  input  logic [4:0]                   in_channel,
  input  logic signed [16:0]           in_stimulus_value,
  // result channel
  output logic                         out_valid,
  output logic [lif_pkg::TIME_W-1:0]   out_spike_time,
  output logic [lif_pkg::CHAN_W-1:0]   out_spike_channel,
  output logic [lif_pkg::AMP_W-1:0]    out_spike_amplitude,
  output logic                         out_last,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lif_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_t;

  state_t               state_r;
  logic [CH_IDX_W-1:0]  idx_r;
  logic [SPK_CNT_W-1:0] cnt_r;
  logic [TIME_W-1:0]    tick_r;
  logic [15:0]          lfsr_r;
  logic [7:0]           leak_r;
  logic [7:0]           decay_r;
  logic                 noise_en_r;

  // spike held until the next spike or the end of the tick
  logic                 pend_v_r;
  logic [CHAN_W-1:0]    pend_chan_r;
  logic [AMP_W-1:0]     pend_amp_r;

  logic                 out_valid_r;
  logic [TIME_W-1:0]    out_time_r;
  logic [CHAN_W-1:0]    out_chan_r;
  logic [AMP_W-1:0]     out_amp_r;
  logic                 out_last_r;

  logic                 accept;
  logic                 set_acc;
  logic                 tick_acc;
  logic                 cfg_wr;
  logic                 shift_en;
  logic [15:0]          lfsr_step;
  logic signed [NOISE_W-1:0] noise;
  stim_t                stim_clamped;
  upd_t                 upd;

  pot_t  cell_pot  [CHANNELS];
  stim_t cell_stim [CHANNELS];

  assign accept   = start && !busy;
  assign set_acc  = accept && in_kind;
  assign tick_acc = accept && !in_kind;
  assign cfg_wr   = psel && penable && pwrite;
  assign shift_en = (state_r == S_RUN);
  assign busy     = (state_r != S_IDLE);
  assign pready   = 1'b1;

  // clamp an incoming stimulus to +/-150 mV
  always_comb begin
    if (in_stimulus_value > STIM_POS) begin
      stim_clamped = STIM_POS;
    end else if (in_stimulus_value < STIM_NEG) begin
      stim_clamped = STIM_NEG;
    end else begin
      stim_clamped = in_stimulus_value;
    end
  end

  // Galois LFSR advance; noise comes from the advanced value
  always_comb begin
    lfsr_step = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 16'h0000);
    if (noise_en_r) begin
      noise = $signed({1'b0, lfsr_step[9:0]}) - 11'sd512;
    end else begin
      noise = '0;
    end
  end

  // ring of cells: slot 0 feeds the update unit, whose result re-enters
  // at the tail, so after CHANNELS shifts every channel is back in place
  generate
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
      pot_t  pot_in;
      stim_t stim_in;
      logic  wr_en;
      if (i == CHANNELS - 1) begin : g_tail
        assign pot_in  = upd.pot;
        assign stim_in = upd.stim;
      end else begin : g_body
        assign pot_in  = cell_pot[i+1];
        assign stim_in = cell_stim[i+1];
      end
      assign wr_en = set_acc && (32'(in_channel) == i);
      lif_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .pot_in   (pot_in),
        .stim_in  (stim_in),
        .wr_en    (wr_en),
        .wr_stim  (stim_clamped),
        .pot_out  (cell_pot[i]),
        .stim_out (cell_stim[i])
      );
    end
  endgenerate

  lif_update u_update (
    .pot_i   (cell_pot[0]),
    .stim_i  (cell_stim[0]),
    .leak_i  (leak_r),
    .decay_i (decay_r),
    .noise_i (noise),
    .upd_o   (upd)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leak_r     <= LEAK_RST;
      decay_r    <= DECAY_RST;
      noise_en_r <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LEAK:  leak_r     <= pwdata[7:0];
        REG_DECAY: decay_r    <= pwdata[7:0];
        REG_NOISE: noise_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LEAK:  prdata = {24'b0, leak_r};
      REG_DECAY: prdata = {24'b0, decay_r};
      REG_NOISE: prdata = {31'b0, noise_en_r};
      default:   prdata = '0;
    endcase
  end

  // sequencer, spike hold stage and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      tick_r      <= '0;
      lfsr_r      <= LFSR_SEED;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (tick_acc) begin
            tick_r  <= tick_r + 1'b1;
            idx_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (noise_en_r) begin
            lfsr_r <= lfsr_step;
          end
          if (upd.fire && (cnt_r < SPK_CNT_W'(SPIKE_CAP))) begin
            cnt_r <= cnt_r + 1'b1;
            // release the held spike, it is not the final one
            if (pend_v_r) begin
              out_valid_r <= 1'b1;
              out_time_r  <= tick_r;
              out_chan_r  <= pend_chan_r;
              out_amp_r   <= pend_amp_r;
              out_last_r  <= 1'b0;
            end
            pend_v_r    <= 1'b1;
            pend_chan_r <= CHAN_W'(idx_r);
            pend_amp_r  <= upd.amp;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == CH_IDX_W'(CHANNELS - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (pend_v_r) begin
            out_valid_r <= 1'b1;
            out_time_r  <= tick_r;
            out_chan_r  <= pend_chan_r;
            out_amp_r   <= pend_amp_r;
            out_last_r  <= 1'b1;
          end
          pend_v_r <= 1'b0;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_spike_time      = out_time_r;
  assign out_spike_channel   = out_chan_r;
  assign out_spike_amplitude = out_amp_r;
  assign out_last            = out_last_r;

endmodule

// ----- rtl/core/lif_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_chk
// Port-level checks of the neuron array, bound to the top level.
// ----------------------------------------------------------------------------
module lif_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid,
  input logic out_last
);

  // a set-stimulus transaction completes in its accept cycle
  a_set_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind |=> !busy)
    else $error("set-stimulus raised busy");

  // a tick keeps the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_kind |=> busy)
    else $error("tick did not raise busy");

  // results come only out of a running tick
  a_out_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a running tick");

  // a non-final spike is shown while the tick still runs
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final spike after tick end");

  // nothing follows the final spike directly
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after final spike");

endmodule

bind leaky_integrate_fire_array lif_chk u_lif_chk (.*);
